FILE: design/assert_macros.svh
// Assertion macros for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checked at every clock edge outside reset.
`define CHK_ASSERT(label, clk, rst, prop) \
  label: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error("assertion failed");

// Checked at every clock edge, reset included.
`define CHK_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("assertion failed");

`endif

FILE: design/pcaf_pkg.sv
`default_nettype none
package pcaf_pkg;

  localparam int LIFE_BITS = 16;
  localparam int CHAN_BITS = 8;
  // Numerator is at most 255 times the divisor.
  localparam int NUM_BITS = CHAN_BITS + LIFE_BITS;
  localparam int DIV_STAGES = 4;
  localparam int BITS_PER_STAGE = CHAN_BITS / DIV_STAGES;
  localparam int LANES = 4;
  localparam int ADDR_BITS = 5;

  typedef enum logic [2:0] {
    REG_COLOR_MODE  = 3'd0,
    REG_ALPHA_MODE  = 3'd1,
    REG_COLOR_START = 3'd2,
    REG_COLOR_MID   = 3'd3,
    REG_COLOR_END   = 3'd4,
    REG_ALPHA_START = 3'd5,
    REG_ALPHA_MID   = 3'd6,
    REG_ALPHA_END   = 3'd7
  } cfg_reg_t;

  localparam logic [2:0] CMODE_TWO   = 3'd1;
  localparam logic [2:0] CMODE_THREE = 3'd2;
  localparam logic [1:0] AMODE_TWO   = 2'd1;
  localparam logic [1:0] AMODE_THREE = 2'd2;

  typedef struct packed {
    logic [LIFE_BITS-1:0] life_left;
    logic [LIFE_BITS-1:0] life_total;
    logic                 type_alive;
    logic [23:0]          color_in;
    logic [7:0]           alpha_in;
  } in_t;

  typedef struct packed {
    logic [23:0] color_out;
    logic [7:0]  alpha_out;
  } out_t;

  typedef struct packed {
    logic [LIFE_BITS-1:0] w1;
    logic [LIFE_BITS-1:0] w2;
    logic                 seg2;
  } weights_t;

  // Weights of the two endpoints; they always sum to the divisor.
  function automatic weights_t calc_weights(input logic [LIFE_BITS-1:0] l,
                                            input logic [LIFE_BITS-1:0] t,
                                            input logic three);
    weights_t             w;
    logic [LIFE_BITS-1:0] ls;
    logic [LIFE_BITS-1:0] e;
    logic [LIFE_BITS:0]   e2;
    logic [LIFE_BITS:0]   tt;
    ls = (l > t) ? t : l;
    e = t - ls;
    e2 = {e, 1'b0};
    tt = {1'b0, t};
    w.seg2 = 1'b0;
    if (t == '0) begin
      w.w1 = LIFE_BITS'(1);
      w.w2 = '0;
    end else if (!three) begin
      w.w1 = ls;
      w.w2 = e;
    end else if (e2 <= tt) begin
      w.w1 = LIFE_BITS'(tt - e2);
      w.w2 = LIFE_BITS'(e2);
    end else begin
      w.seg2 = 1'b1;
      w.w1 = LIFE_BITS'({ls, 1'b0});
      w.w2 = LIFE_BITS'(e2 - tt);
    end
    return w;
  endfunction

endpackage
`default_nettype wire

FILE: design/particle_color_alpha_fade.sv
// Particle color and alpha fade over life.
// Input channel (in_valid, in_stall, in_data) carries one particle per
// transfer: life left, total life, type-alive flag, current color and alpha.
// Output channel (out_valid, out_stall, out_data) returns one transfer per
// input transfer, in order, with the faded color and alpha.
// Seven register stages: one input register, one weight stage, one multiply
// stage and four divider stages that each resolve two quotient bits.
// Throughput is one particle per cycle while the output is not stalled.
// Every stage holds its own valid bit and loads whenever the stage after it
// moves or it is empty, so bubbles close up while the output is stalled.
// in_stall rises only when all seven stages hold data and out_stall is high;
// a stalled output keeps its data unchanged.
// The user must write the registers over the APB port only while no
// particle is in flight; the block itself does not enforce this.
// Synchronous reset empties the pipeline and loads the register defaults.
`default_nettype none
module particle_color_alpha_fade (
  input  wire logic                              clk,
  input  wire logic                              rst,
  input  wire logic                              in_valid,
  output logic                                   in_stall,
  input  wire pcaf_pkg::in_t                     in_data,
  output logic                                   out_valid,
  input  wire logic                              out_stall,
  output pcaf_pkg::out_t                         out_data,
  input  wire logic                              psel,
  input  wire logic                              penable,
  input  wire logic                              pwrite,
  input  wire logic [pcaf_pkg::ADDR_BITS-1:0]    paddr,
  input  wire logic [31:0]                       pwdata,
  output logic [31:0]                            prdata,
  output logic                                   pready
);

  localparam int NST = 3 + pcaf_pkg::DIV_STAGES;

  logic [2:0]  color_mode;
  logic [1:0]  alpha_mode;
  logic [23:0] color_start, color_mid, color_end;
  logic [7:0]  alpha_start, alpha_mid, alpha_end;

  pcaf_pkg::cfg_reg_t reg_idx;
  logic wr;

  assign pready = 1'b1;
  assign reg_idx = pcaf_pkg::cfg_reg_t'(paddr[pcaf_pkg::ADDR_BITS-1:2]);
  assign wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      color_mode <= '0;
      alpha_mode <= '0;
      color_start <= 24'hFFFFFF;
      color_mid <= 24'hFFFFFF;
      color_end <= 24'hFFFFFF;
      alpha_start <= 8'hFF;
      alpha_mid <= 8'hFF;
      alpha_end <= 8'hFF;
    end else if (wr) begin
      unique case (reg_idx)
        pcaf_pkg::REG_COLOR_MODE:  color_mode <= pwdata[2:0];
        pcaf_pkg::REG_ALPHA_MODE:  alpha_mode <= pwdata[1:0];
        pcaf_pkg::REG_COLOR_START: color_start <= pwdata[23:0];
        pcaf_pkg::REG_COLOR_MID:   color_mid <= pwdata[23:0];
        pcaf_pkg::REG_COLOR_END:   color_end <= pwdata[23:0];
        pcaf_pkg::REG_ALPHA_START: alpha_start <= pwdata[7:0];
        pcaf_pkg::REG_ALPHA_MID:   alpha_mid <= pwdata[7:0];
        pcaf_pkg::REG_ALPHA_END:   alpha_end <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      pcaf_pkg::REG_COLOR_MODE:  prdata = {29'd0, color_mode};
      pcaf_pkg::REG_ALPHA_MODE:  prdata = {30'd0, alpha_mode};
      pcaf_pkg::REG_COLOR_START: prdata = {8'd0, color_start};
      pcaf_pkg::REG_COLOR_MID:   prdata = {8'd0, color_mid};
      pcaf_pkg::REG_COLOR_END:   prdata = {8'd0, color_end};
      pcaf_pkg::REG_ALPHA_START: prdata = {24'd0, alpha_start};
      pcaf_pkg::REG_ALPHA_MID:   prdata = {24'd0, alpha_mid};
      pcaf_pkg::REG_ALPHA_END:   prdata = {24'd0, alpha_end};
      default:                   prdata = '0;
    endcase
  end

  // Pipeline control: a stage loads when it is empty or the next one moves.
  logic [NST-1:0] valid;
  logic [NST:0]   en;

  always_comb begin
    en[NST] = !out_stall;
    for (int k = NST - 1; k >= 0; k--) begin
      en[k] = !valid[k] || en[k+1];
    end
  end

  assign in_stall = !en[0];
  assign out_valid = valid[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= '0;
    end else begin
      if (en[0]) begin
        valid[0] <= in_valid;
      end
      for (int k = 1; k < NST; k++) begin
        if (en[k]) begin
          valid[k] <= valid[k-1];
        end
      end
    end
  end

  // Pass-through data and lerp flags travel alongside the datapath.
  pcaf_pkg::in_t s0;
  logic [23:0] col_p [1:NST-1];
  logic [7:0]  alp_p [1:NST-1];
  logic        col_l [1:NST-1];
  logic        alp_l [1:NST-1];

  pcaf_pkg::weights_t cw, aw;
  logic [pcaf_pkg::LIFE_BITS-1:0] div_d;

  assign cw = pcaf_pkg::calc_weights(s0.life_left, s0.life_total,
                                     color_mode == pcaf_pkg::CMODE_THREE);
  assign aw = pcaf_pkg::calc_weights(s0.life_left, s0.life_total,
                                     alpha_mode == pcaf_pkg::AMODE_THREE);
  assign div_d = (s0.life_total == '0) ? pcaf_pkg::LIFE_BITS'(1) : s0.life_total;

  // Stage 1 operands for the four lanes: red, green, blue, alpha.
  logic [7:0] x1 [0:pcaf_pkg::LANES-1];
  logic [7:0] y1 [0:pcaf_pkg::LANES-1];
  logic [pcaf_pkg::LIFE_BITS-1:0] w1a, w2a, w1c, w2c, d1;

  always_ff @(posedge clk) begin
    if (en[0]) begin
      s0 <= in_data;
    end
    if (en[1]) begin
      col_p[1] <= s0.color_in;
      alp_p[1] <= s0.alpha_in;
      col_l[1] <= s0.type_alive && (color_mode == pcaf_pkg::CMODE_TWO ||
                                    color_mode == pcaf_pkg::CMODE_THREE);
      alp_l[1] <= s0.type_alive && (alpha_mode == pcaf_pkg::AMODE_TWO ||
                                    alpha_mode == pcaf_pkg::AMODE_THREE);
      for (int k = 0; k < 3; k++) begin
        x1[k] <= cw.seg2 ? color_mid[8*k +: 8] : color_start[8*k +: 8];
        y1[k] <= cw.seg2 ? color_end[8*k +: 8] : color_mid[8*k +: 8];
      end
      x1[3] <= aw.seg2 ? alpha_mid : alpha_start;
      y1[3] <= aw.seg2 ? alpha_end : alpha_mid;
      w1c <= cw.w1;
      w2c <= cw.w2;
      w1a <= aw.w1;
      w2a <= aw.w2;
      d1 <= div_d;
    end
    for (int k = 2; k < NST; k++) begin
      if (en[k]) begin
        col_p[k] <= col_p[k-1];
        alp_p[k] <= alp_p[k-1];
        col_l[k] <= col_l[k-1];
        alp_l[k] <= alp_l[k-1];
      end
    end
  end

  logic [7:0] q [0:pcaf_pkg::LANES-1];

  for (genvar g = 0; g < pcaf_pkg::LANES; g++) begin : g_lane
    pcaf_lerp u_lerp (
      .clk (clk),
      .en  (en[NST-1:2]),
      .x   (x1[g]),
      .y   (y1[g]),
      .w1  ((g == pcaf_pkg::LANES - 1) ? w1a : w1c),
      .w2  ((g == pcaf_pkg::LANES - 1) ? w2a : w2c),
      .d   (d1),
      .q   (q[g])
    );
  end

  assign out_data.color_out = col_l[NST-1] ? {q[2], q[1], q[0]} : col_p[NST-1];
  assign out_data.alpha_out = alp_l[NST-1] ? q[3] : alp_p[NST-1];

endmodule
`default_nettype wire

FILE: design/pcaf_lerp.sv
`default_nettype none
module pcaf_lerp (
  input  wire logic                                  clk,
  input  wire logic [pcaf_pkg::DIV_STAGES:0]         en,
  input  wire logic [pcaf_pkg::CHAN_BITS-1:0]        x,
  input  wire logic [pcaf_pkg::CHAN_BITS-1:0]        y,
  input  wire logic [pcaf_pkg::LIFE_BITS-1:0]        w1,
  input  wire logic [pcaf_pkg::LIFE_BITS-1:0]        w2,
  input  wire logic [pcaf_pkg::LIFE_BITS-1:0]        d,
  output logic      [pcaf_pkg::CHAN_BITS-1:0]        q
);

  logic [pcaf_pkg::NUM_BITS-1:0]  rem [0:pcaf_pkg::DIV_STAGES];
  logic [pcaf_pkg::CHAN_BITS-1:0] qv  [0:pcaf_pkg::DIV_STAGES];
  logic [pcaf_pkg::LIFE_BITS-1:0] dv  [0:pcaf_pkg::DIV_STAGES];
  logic [pcaf_pkg::NUM_BITS-1:0]  rem_next [1:pcaf_pkg::DIV_STAGES];
  logic [pcaf_pkg::CHAN_BITS-1:0] qv_next  [1:pcaf_pkg::DIV_STAGES];

  // Restoring division, two quotient bits per stage, most significant first.
  always_comb begin
    logic [pcaf_pkg::NUM_BITS-1:0] r;
    logic [pcaf_pkg::NUM_BITS-1:0] sh;
    logic [pcaf_pkg::CHAN_BITS-1:0] qq;
    int b;
    for (int j = 0; j < pcaf_pkg::DIV_STAGES; j++) begin
      r = rem[j];
      qq = qv[j];
      for (int s = 0; s < pcaf_pkg::BITS_PER_STAGE; s++) begin
        b = pcaf_pkg::CHAN_BITS - 1 - j * pcaf_pkg::BITS_PER_STAGE - s;
        sh = pcaf_pkg::NUM_BITS'(dv[j]) << b;
        if (r >= sh) begin
          r = r - sh;
          qq[b] = 1'b1;
        end
      end
      rem_next[j+1] = r;
      qv_next[j+1] = qq;
    end
  end

  always_ff @(posedge clk) begin
    if (en[0]) begin
      rem[0] <= pcaf_pkg::NUM_BITS'(x) * pcaf_pkg::NUM_BITS'(w1)
              + pcaf_pkg::NUM_BITS'(y) * pcaf_pkg::NUM_BITS'(w2);
      qv[0] <= '0;
      dv[0] <= d;
    end
    for (int j = 1; j <= pcaf_pkg::DIV_STAGES; j++) begin
      if (en[j]) begin
        rem[j] <= rem_next[j];
        qv[j] <= qv_next[j];
        dv[j] <= dv[j-1];
      end
    end
  end

  assign q = qv[pcaf_pkg::DIV_STAGES];

endmodule
`default_nettype wire

FILE: design/pcaf_chk.sv
`default_nettype none
`include "assert_macros.svh"
module pcaf_chk (
  input wire logic           clk,
  input wire logic           rst,
  input wire logic           in_valid,
  input wire logic           in_stall,
  input wire logic           out_valid,
  input wire logic           out_stall,
  input wire pcaf_pkg::out_t out_data
);

  `CHK_ASSERT_ALWAYS(a_reset_empty, clk, rst |=> !out_valid)
  `CHK_ASSERT(a_stall_only_when_full, clk, rst, in_stall |-> (out_valid && out_stall))
  `CHK_ASSERT(a_out_hold, clk, rst, (out_valid && out_stall) |=> (out_valid && $stable(out_data)))
  `CHK_ASSERT(a_free_flow, clk, rst, !out_stall |-> !in_stall)

endmodule

bind particle_color_alpha_fade pcaf_chk u_pcaf_chk (
  .clk       (clk),
  .rst       (rst),
  .in_valid  (in_valid),
  .in_stall  (in_stall),
  .out_valid (out_valid),
  .out_stall (out_stall),
  .out_data  (out_data)
);
`default_nettype wire
